@@ src/assert_macros.svh @@
// Assertion macros used by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/tsq_pkg.sv @@
`default_nettype none

package tsq_pkg;

    localparam int OP_W    = 3;
    localparam int QSEL_W  = 3;
    localparam int PID_W   = 8;
    localparam int CODE_W  = 3;
    localparam int PCNT_W  = 5;

    localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOK = 3'd3;
    localparam logic [OP_W-1:0] OP_PULL = 3'd4;

    localparam logic [CODE_W-1:0] RC_OK        = 3'd0;
    localparam logic [CODE_W-1:0] RC_EMPTY     = 3'd1;
    localparam logic [CODE_W-1:0] RC_FULL      = 3'd2;
    localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd3;
    localparam logic [CODE_W-1:0] RC_INVALID   = 3'd4;

    typedef struct packed {
        logic              en;
        logic              shift_all;
        logic              pull;
        logic [QSEL_W-1:0] q;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ src/thread_status_queues_top.sv @@
// Thread status queues: one FIFO of thread ids for each scheduling status.
// Requests arrive on the input channel (i_in_valid / o_in_ready) carrying an
// operation, a queue number and a thread id. Each request yields exactly one
// result on the output channel (o_out_valid / i_out_ready): a status code,
// the id returned and the selected queue's entry count after the operation.
// A request is first captured in a register, then evaluated in the
// chain of slot cells, where every cell compares its id in parallel and the
// match flag ripples toward the tail to pick the slots that shift on a pull.
// The result is registered when the captured request is evaluated, and a
// new request is taken only after the previous one has been evaluated.
// When the receiver stalls, the result holds and the captured request waits
// in front of the cell chain; no further request is taken until it moves on.
// Reset empties every queue and clears the handshake state; slot contents
// are not cleared and are never read before they are written.
`default_nettype none

module thread_status_queues_top #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [tsq_pkg::OP_W-1:0]         i_op,
    input  wire  [tsq_pkg::QSEL_W-1:0]       i_queue_sel,
    input  wire  [tsq_pkg::PID_W-1:0]        i_thread_id,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [tsq_pkg::CODE_W-1:0]       o_result_code,
    output logic [tsq_pkg::PID_W-1:0]        o_id_out,
    output logic [tsq_pkg::PCNT_W-1:0]       o_queue_count
);

    localparam int Q_W    = $clog2(NUM_QUEUES);
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW_W  = (ID_BITS > tsq_pkg::PID_W) ? ID_BITS : tsq_pkg::PID_W;
    localparam int CNTW_W = (LEN_W > tsq_pkg::PCNT_W) ? LEN_W : tsq_pkg::PCNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [tsq_pkg::OP_W-1:0]     r_op;
    logic [tsq_pkg::QSEL_W-1:0]   r_q;
    logic [ID_BITS-1:0]           r_id;
    logic [LEN_W-1:0]             r_len [NUM_QUEUES];

    logic                         r_out_valid;
    logic [tsq_pkg::CODE_W-1:0]   r_code;
    logic [ID_BITS-1:0]           r_res_id;
    logic [LEN_W-1:0]             r_cnt;

    logic [tsq_pkg::CODE_W-1:0]   n_code;
    logic [ID_BITS-1:0]           n_res_id;
    logic [LEN_W-1:0]             n_cnt;

    logic                         w_accept;
    logic                         w_commit;
    logic                         w_q_ok;
    logic [Q_W-1:0]               w_qi;
    logic [LEN_W-1:0]             w_len;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_found;
    logic                         w_enq_ok;
    logic                         w_deq_ok;
    logic                         w_pull_ok;
    logic [IDW_W-1:0]             w_in_wide;
    logic [IDW_W-1:0]             w_out_wide;
    logic [CNTW_W-1:0]            w_cnt_wide;

    tsq_pkg::t_cell_cmd           w_cmd;
    logic [ID_BITS-1:0]           w_word [QUEUE_DEPTH];
    logic [ID_BITS-1:0]           w_nbr  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]         w_find;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);

    assign w_in_wide  = IDW_W'(i_thread_id);

    assign w_q_ok  = ({1'b0, r_q} < (tsq_pkg::QSEL_W + 1)'(NUM_QUEUES));
    assign w_qi    = w_q_ok ? r_q[Q_W-1:0] : '0;
    assign w_len   = w_q_ok ? r_len[w_qi] : '0;
    assign w_full  = (w_len == LEN_W'(QUEUE_DEPTH));
    assign w_empty = (w_len == '0);
    assign w_found = w_find[QUEUE_DEPTH];

    assign w_enq_ok  = w_q_ok && (r_op == tsq_pkg::OP_ENQ) && !w_full;
    assign w_deq_ok  = w_q_ok && (r_op == tsq_pkg::OP_DEQ) && !w_empty;
    assign w_pull_ok = w_q_ok && (r_op == tsq_pkg::OP_PULL) && w_found;

    assign w_cmd.en        = w_commit && w_q_ok;
    assign w_cmd.shift_all = w_deq_ok;
    assign w_cmd.pull      = (r_op == tsq_pkg::OP_PULL);
    assign w_cmd.q         = tsq_pkg::QSEL_W'(w_qi);

    assign w_find[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_nbr[i] = '0;
        end else begin : g_mid
            assign w_nbr[i] = w_word[i+1];
        end

        tsq_cell #(
            .NUM_QUEUES (NUM_QUEUES),
            .ID_BITS    (ID_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_key   (r_id),
            .i_nbr   (w_nbr[i]),
            .i_live  (LEN_W'(i) < w_len),
            .i_write (w_enq_ok && (w_len == LEN_W'(i))),
            .i_find  (w_find[i]),
            .o_find  (w_find[i+1]),
            .o_word  (w_word[i])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_code   = tsq_pkg::RC_OK;
        n_res_id = '0;
        n_cnt    = w_len;
        if (!w_q_ok) begin
            n_code = tsq_pkg::RC_INVALID;
        end else begin
            unique case (r_op) inside
                tsq_pkg::OP_ENQ: begin
                    if (w_full) begin
                        n_code = tsq_pkg::RC_FULL;
                    end else begin
                        n_cnt = w_len + 1'b1;
                    end
                end
                tsq_pkg::OP_DEQ, tsq_pkg::OP_PEEK: begin
                    if (w_empty) begin
                        n_code = tsq_pkg::RC_EMPTY;
                    end else begin
                        n_res_id = w_word[0];
                        if (r_op == tsq_pkg::OP_DEQ) begin
                            n_cnt = w_len - 1'b1;
                        end
                    end
                end
                tsq_pkg::OP_LOOK, tsq_pkg::OP_PULL: begin
                    if (!w_found) begin
                        n_code = tsq_pkg::RC_NOT_FOUND;
                    end else begin
                        n_res_id = r_id;
                        if (r_op == tsq_pkg::OP_PULL) begin
                            n_cnt = w_len - 1'b1;
                        end
                    end
                end
                default: begin
                    n_code = tsq_pkg::RC_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_len[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && w_enq_ok) begin
                r_len[w_qi] <= w_len + 1'b1;
            end else if (w_commit && (w_deq_ok || w_pull_ok)) begin
                r_len[w_qi] <= w_len - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op;
            r_q  <= i_queue_sel;
            r_id <= ID_BITS'(w_in_wide);
        end
        if (w_commit) begin
            r_code   <= n_code;
            r_res_id <= n_res_id;
            r_cnt    <= n_cnt;
        end
    end

    assign w_out_wide    = IDW_W'(r_res_id);
    assign w_cnt_wide    = CNTW_W'(r_cnt);
    assign o_out_valid   = r_out_valid;
    assign o_result_code = r_code;
    assign o_id_out      = w_out_wide[tsq_pkg::PID_W-1:0];
    assign o_queue_count = w_cnt_wide[tsq_pkg::PCNT_W-1:0];

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_evaluates, w_accept, r_state == S_EVAL)
    `ASSERT_NEXT(a_commit_gives_result, w_commit, o_out_valid)
    `ASSERT_NEXT(a_pull_drops_count, w_commit && w_pull_ok, w_len == $past(w_len) - 1'b1)

endmodule

`default_nettype wire

@@ src/tsq_cell.sv @@
`default_nettype none

module tsq_cell #(
    parameter int NUM_QUEUES = 4,
    parameter int ID_BITS    = 8
) (
    input  wire                     i_clk,
    input  wire  tsq_pkg::t_cell_cmd i_cmd,
    input  wire  [ID_BITS-1:0]      i_key,
    input  wire  [ID_BITS-1:0]      i_nbr,
    input  wire                     i_live,
    input  wire                     i_write,
    input  wire                     i_find,
    output logic                    o_find,
    output logic [ID_BITS-1:0]      o_word
);

    localparam int Q_W = $clog2(NUM_QUEUES);

    logic [ID_BITS-1:0] r_word [NUM_QUEUES];
    logic [Q_W-1:0]     w_q;
    logic               w_match;
    logic               w_shift;

    assign w_q     = i_cmd.q[Q_W-1:0];
    assign o_word  = r_word[w_q];
    assign w_match = i_live && (o_word == i_key);
    assign o_find  = i_find | w_match;
    assign w_shift = i_cmd.shift_all | (i_cmd.pull & o_find);

    // A cell at or behind the removed slot takes its neighbor's word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (w_shift) begin
                r_word[w_q] <= i_nbr;
            end else if (i_write) begin
                r_word[w_q] <= i_key;
            end
        end
    end

endmodule

`default_nettype wire
